// ===== rtl/cobs_stream_deframer_defines.svh =====
// Assertion macros shared by the COBS stream deframer RTL.
// Each macro expects clk and arst_n to be visible at the point of use.
`ifndef COBS_STREAM_DEFRAMER_DEFINES_SVH
`define COBS_STREAM_DEFRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("Deframer assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define CSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("Deframer assertion failed.");

`endif

// ===== rtl/csd_pkg.sv =====
// Constants and status codes for the COBS stream deframer.
// Used by cobs_stream_deframer; depends on nothing else.
package csd_pkg;

	localparam int COUNT_BITS = 16;
	localparam int LEN_BITS = 16;
	localparam int CMP_BITS = ((COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS) + 1;

	localparam logic [7:0] CODE_FULL = 8'hff;
	localparam logic [LEN_BITS-1:0] MAX_FRAME_LEN_RESET = 16'd512;
	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam int ADDR_BITS = 3;
	localparam logic REG_MAX_FRAME_LEN = 1'b0;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_OVERFULL = 2'd1,
		STATUS_EMPTY    = 2'd2
	} status_t;

endpackage

// ===== rtl/cobs_stream_deframer.sv =====
// COBS stream deframer: decodes one encoded byte per transaction.
// Depends on csd_pkg and cobs_stream_deframer_defines.svh.
//
// Channel  Direction  Contents
// s_axis   in         tdata[7:0] in_byte
// m_axis   out        tdata[7:0] out_data, [9:8] status, [25:10] frame_len; tlast frame_end
// apb      in         register 0 at byte address 0: max_frame_len[15:0]
//
// One byte is accepted every cycle while s_axis_tready is high; its result, if any, is registered onto m_axis.
// The decode state is updated in the single pass from the input register to the output
// register. Reset clears the decode state and sets max_frame_len to 512.
// A stall on m_axis holds the output register and the input register, and s_axis_tready
// drops only while both are full.
`include "cobs_stream_deframer_defines.svh"

module cobs_stream_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [7:0] in_byte
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [31:0]                   m_axis_tdata,  // [7:0] out_data, [9:8] status, [25:10] frame_len
	output logic                          m_axis_tlast,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [csd_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic                               valid_s1;
	logic [7:0]                         byte_s1;
	logic                               adv;
	logic [csd_pkg::LEN_BITS-1:0]       max_len_q;
	logic [7:0]                         block_left_q, block_left_d;
	logic [7:0]                         prev_code_q, prev_code_d;
	logic [csd_pkg::COUNT_BITS-1:0]     enc_count_q, enc_count_d;
	logic [csd_pkg::COUNT_BITS-1:0]     dec_count_q, dec_count_d;
	logic                               overfull_q, overfull_d;
	logic [csd_pkg::CMP_BITS-1:0]       enc_inc;
	logic [csd_pkg::CMP_BITS-1:0]       dec_ext;
	logic                               limit_hit;
	logic [csd_pkg::LEN_BITS-1:0]       len_sat;
	logic                               res_valid;
	logic [7:0]                         res_data;
	logic                               res_end;
	csd_pkg::status_t                   res_status;
	logic [csd_pkg::LEN_BITS-1:0]       res_len;
	logic                               out_valid_q;
	logic [7:0]                         out_data_q;
	logic                               out_end_q;
	csd_pkg::status_t                   out_status_q;
	logic [csd_pkg::LEN_BITS-1:0]       out_len_q;

	assign pready = 1'b1;
	assign prdata = (paddr[csd_pkg::ADDR_BITS-1] == csd_pkg::REG_MAX_FRAME_LEN) ?
		{{(32 - csd_pkg::LEN_BITS){1'b0}}, max_len_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= csd_pkg::MAX_FRAME_LEN_RESET;
		end else if (psel && penable && pwrite && pready &&
			paddr[csd_pkg::ADDR_BITS-1] == csd_pkg::REG_MAX_FRAME_LEN) begin
			max_len_q <= pwdata[csd_pkg::LEN_BITS-1:0];
		end
	end

	assign adv = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	assign enc_inc = csd_pkg::CMP_BITS'(enc_count_q) + csd_pkg::CMP_BITS'(1);
	assign limit_hit = enc_inc >= csd_pkg::CMP_BITS'(max_len_q);
	assign dec_ext = csd_pkg::CMP_BITS'(dec_count_q);
	assign len_sat = (dec_ext > csd_pkg::CMP_BITS'(csd_pkg::LEN_MAX)) ?
		csd_pkg::LEN_MAX : dec_ext[csd_pkg::LEN_BITS-1:0];

	always_comb begin
		block_left_d = block_left_q;
		prev_code_d  = prev_code_q;
		enc_count_d  = enc_count_q;
		dec_count_d  = dec_count_q;
		overfull_d   = overfull_q;
		res_valid    = 1'b0;
		res_data     = 8'd0;
		res_end      = 1'b0;
		res_status   = csd_pkg::STATUS_OK;
		res_len      = '0;
		if (byte_s1 == 8'd0) begin
			res_valid = 1'b1;
			res_end   = 1'b1;
			res_len   = len_sat;
			if (overfull_q) begin
				res_status = csd_pkg::STATUS_OVERFULL;
			end else if (dec_count_q == '0) begin
				res_status = csd_pkg::STATUS_EMPTY;
			end
			block_left_d = 8'd0;
			prev_code_d  = csd_pkg::CODE_FULL;
			enc_count_d  = '0;
			dec_count_d  = '0;
			overfull_d   = 1'b0;
		end else if (overfull_q) begin
			overfull_d = 1'b1;
		end else if (limit_hit) begin
			overfull_d = 1'b1;
		end else begin
			if (enc_count_q != csd_pkg::COUNT_MAX) begin
				enc_count_d = enc_inc[csd_pkg::COUNT_BITS-1:0];
			end
			if (block_left_q != 8'd0) begin
				block_left_d = block_left_q - 8'd1;
				res_valid    = 1'b1;
				res_data     = byte_s1;
			end else begin
				prev_code_d  = byte_s1;
				block_left_d = byte_s1 - 8'd1;
				res_valid    = (prev_code_q != csd_pkg::CODE_FULL);
			end
			if (res_valid && dec_count_q != csd_pkg::COUNT_MAX) begin
				dec_count_d = dec_count_q + csd_pkg::COUNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_left_q <= 8'd0;
			prev_code_q  <= csd_pkg::CODE_FULL;
			enc_count_q  <= '0;
			dec_count_q  <= '0;
			overfull_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (adv) begin
			block_left_q <= block_left_d;
			prev_code_q  <= prev_code_d;
			enc_count_q  <= enc_count_d;
			dec_count_q  <= dec_count_d;
			overfull_q   <= overfull_d;
			out_valid_q  <= res_valid;
		end else if (m_axis_tready) begin
			out_valid_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_data_q   <= res_data;
			out_end_q    <= res_end;
			out_status_q <= res_status;
			out_len_q    <= res_len;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_end_q;
	assign m_axis_tdata  = {6'd0, out_len_q, out_status_q, out_data_q};

	`CSD_ASSERT_SAME(a_block_below_code, 1'b1, block_left_q < prev_code_q)
	`CSD_ASSERT_SAME(a_dec_not_above_enc, 1'b1, dec_count_q <= enc_count_q)
	`CSD_ASSERT_SAME(a_data_result_clean, m_axis_tvalid && !m_axis_tlast,
		out_status_q == csd_pkg::STATUS_OK && out_len_q == '0)
	`CSD_ASSERT_NEXT(a_delim_clears, adv && byte_s1 == 8'd0,
		enc_count_q == '0 && dec_count_q == '0 && !overfull_q && m_axis_tvalid && m_axis_tlast)

endmodule
